>>> hdl/ctd_pkg.sv
// ----------------------------------------------------------------------------
// ctd_pkg
// Shared types and constants for the credit trigger dispatcher.
// ----------------------------------------------------------------------------
package ctd_pkg;

  localparam int MAX_BURST_DEF  = 63;
  localparam int EVENT_BITS_DEF = 24;

  localparam int CMD_W     = 3;
  localparam int CREDIT_W  = 32;
  localparam int EV_OUT_W  = 24;
  localparam int RUN_W     = 32;
  localparam int SRC_W     = 12;
  localparam int MAXTRIG_W = 24;
  localparam int STATE_W   = 3;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CONFIGURE = 3'd0,
    CMD_ENABLE    = 3'd1,
    CMD_SUSPEND   = 3'd2,
    CMD_RESUME    = 3'd3,
    CMD_HALT      = 3'd4,
    CMD_FAIL      = 3'd5,
    CMD_CREDIT    = 3'd6,
    CMD_TICK      = 3'd7
  } cmd_t;

  typedef enum logic [STATE_W-1:0] {
    RS_HALTED    = 3'd0,
    RS_READY     = 3'd1,
    RS_ENABLED   = 3'd2,
    RS_SUSPENDED = 3'd3,
    RS_FAILED    = 3'd4
  } run_state_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SOURCE_ID  = 2'd0,
    REG_MAX_TRIG   = 2'd1,
    REG_START_RUN  = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic apply;
    logic emit;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic drain_ok;
    logic out_free;
  } ctl_status_t;

endpackage

>>> hdl/ctd_ctrl.sv
// ----------------------------------------------------------------------------
// ctd_ctrl
// Sequencer that takes one request, then steps the datapath through the
// trigger burst and the closing status result.
// ----------------------------------------------------------------------------
module ctd_ctrl
  import ctd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ctl_status_t status,
  output ctl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    CS_IDLE  = 2'b01,
    CS_DRAIN = 2'b10
  } ctl_state_t;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.apply  = 1'b1;
          state_next = CS_DRAIN;
        end
      end
      CS_DRAIN: begin
        if (status.out_free) begin
          if (status.drain_ok) begin
            cmd.emit = 1'b1;
          end else begin
            cmd.finish = 1'b1;
            state_next = CS_IDLE;
          end
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> state == CS_DRAIN)
    else $error("apply did not start a drain");

  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> in_ready)
    else $error("finish did not return to idle");

  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.apply, cmd.emit, cmd.finish}))
    else $error("more than one datapath command at once");

endmodule

>>> hdl/ctd_datapath.sv
// ----------------------------------------------------------------------------
// ctd_datapath
// Run state, credit counter, event counter, configuration registers and the
// output register of the credit trigger dispatcher.
// ----------------------------------------------------------------------------
module ctd_datapath
  import ctd_pkg::*;
#(
  parameter int MAX_BURST  = MAX_BURST_DEF,
  parameter int EVENT_BITS = EVENT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  input  logic [CMD_W-1:0]     command,
  input  logic [CREDIT_W-1:0]  credit_count,
  input  ctl_cmd_t             cmd,
  output ctl_status_t          status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 is_trigger,
  output logic [EV_OUT_W-1:0]  event_number,
  output logic [RUN_W-1:0]     run_number,
  output logic [SRC_W-1:0]     trigger_source,
  output logic [STATE_W-1:0]   state_code,
  output logic                 accepted,
  output logic                 last
);

  localparam int BURST_W = $clog2(MAX_BURST + 1);
  localparam int CMP_W   = (EVENT_BITS > MAXTRIG_W) ? EVENT_BITS : MAXTRIG_W;

  logic [SRC_W-1:0]      source_id;
  logic [MAXTRIG_W-1:0]  max_triggers;
  logic [RUN_W-1:0]      start_run_number;

  run_state_t            run_state, run_state_next;
  logic [CREDIT_W-1:0]   pending, pending_next;
  logic [EVENT_BITS-1:0] next_event, next_event_next;
  logic [RUN_W-1:0]      halts_seen, halts_seen_next;
  logic                  acc, acc_next;
  logic [BURST_W-1:0]    burst;

  logic [CMP_W-1:0]      ev_ext;
  logic [CREDIT_W:0]     credit_sum;
  logic                  ev_in_range;
  logic                  reg_write;
  reg_idx_t              reg_idx;
  cmd_t                  in_cmd;

  assign reg_write = psel && penable && pwrite;
  assign reg_idx   = reg_idx_t'(paddr[APB_AW-1:APB_AW-REG_IDX_W]);
  assign in_cmd    = cmd_t'(command);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_id        <= '0;
      max_triggers     <= '0;
      start_run_number <= '0;
    end else if (reg_write) begin
      case (reg_idx)
        REG_SOURCE_ID: source_id        <= pwdata[SRC_W-1:0];
        REG_MAX_TRIG:  max_triggers     <= pwdata[MAXTRIG_W-1:0];
        REG_START_RUN: start_run_number <= pwdata[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SOURCE_ID: prdata = APB_DW'(source_id);
      REG_MAX_TRIG:  prdata = APB_DW'(max_triggers);
      REG_START_RUN: prdata = APB_DW'(start_run_number);
      default:       prdata = '0;
    endcase
  end

  assign ev_ext      = CMP_W'(next_event);
  assign ev_in_range = ev_ext <= CMP_W'(max_triggers);
  assign credit_sum  = {1'b0, pending} + {1'b0, credit_count};

  assign status.drain_ok = (run_state == RS_ENABLED) && (pending != '0) &&
                           ev_in_range && (burst < BURST_W'(MAX_BURST));
  assign status.out_free = !out_valid || out_ready;

  always_comb begin
    run_state_next  = run_state;
    pending_next    = pending;
    next_event_next = next_event;
    halts_seen_next = halts_seen;
    acc_next        = acc;
    if (cmd.apply) begin
      acc_next = 1'b1;
      unique case (in_cmd)
        CMD_CONFIGURE: begin
          if (run_state == RS_HALTED) run_state_next = RS_READY;
          else acc_next = 1'b0;
        end
        CMD_ENABLE: begin
          if (run_state == RS_READY) run_state_next = RS_ENABLED;
          else acc_next = 1'b0;
        end
        CMD_SUSPEND: begin
          if (run_state == RS_ENABLED) run_state_next = RS_SUSPENDED;
          else acc_next = 1'b0;
        end
        CMD_RESUME: begin
          if (run_state == RS_SUSPENDED) run_state_next = RS_ENABLED;
          else acc_next = 1'b0;
        end
        CMD_HALT: begin
          if (run_state != RS_FAILED) begin
            run_state_next  = RS_HALTED;
            halts_seen_next = halts_seen + RUN_W'(1);
            next_event_next = EVENT_BITS'(1);
            pending_next    = '0;
          end else begin
            acc_next = 1'b0;
          end
        end
        CMD_FAIL: begin
          run_state_next = RS_FAILED;
        end
        CMD_CREDIT: begin
          if (run_state == RS_READY || run_state == RS_SUSPENDED ||
              run_state == RS_ENABLED) begin
            pending_next = credit_sum[CREDIT_W] ? '1 : credit_sum[CREDIT_W-1:0];
          end
        end
        default: ;
      endcase
    end else if (cmd.emit) begin
      pending_next    = pending - CREDIT_W'(1);
      next_event_next = next_event + EVENT_BITS'(1);
    end else if (cmd.finish) begin
      if (run_state == RS_ENABLED && !ev_in_range) pending_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_state  <= RS_HALTED;
      pending    <= '0;
      next_event <= EVENT_BITS'(1);
      halts_seen <= '0;
      acc        <= 1'b0;
      burst      <= '0;
    end else begin
      run_state  <= run_state_next;
      pending    <= pending_next;
      next_event <= next_event_next;
      halts_seen <= halts_seen_next;
      acc        <= acc_next;
      if (cmd.apply) begin
        burst <= '0;
      end else if (cmd.emit) begin
        burst <= burst + BURST_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit || cmd.finish) begin
      is_trigger     <= cmd.emit;
      event_number   <= EV_OUT_W'(ev_ext);
      run_number     <= start_run_number + halts_seen;
      trigger_source <= source_id;
      state_code     <= run_state;
      accepted       <= acc;
      last           <= cmd.finish;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> run_state == RS_ENABLED && pending != '0)
    else $error("trigger emitted without an enabled run and a credit");

  assert property (@(posedge clk) disable iff (rst)
    burst <= BURST_W'(MAX_BURST))
    else $error("burst count exceeded its limit");

  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid && last && !is_trigger)
    else $error("closing status not loaded");

endmodule

>>> hdl/credit_trigger_dispatcher_top.sv
// ----------------------------------------------------------------------------
// credit_trigger_dispatcher_top
// Run-control state machine that turns credits into numbered triggers.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// cfg       in         APB psel/penable      paddr, pwdata, prdata
// request   in         in_valid/in_ready     command, credit_count
// result    out        out_valid/out_ready   is_trigger .. last
//
// A request's triggers leave the output register one per cycle while the result
// side never stalls, then the status result follows; the next request is
// accepted only after that status result has been issued.
// Reset is synchronous; no clearing pass is needed.
// A stall on the result side holds the burst in place.
// ----------------------------------------------------------------------------
module credit_trigger_dispatcher_top
  import ctd_pkg::*;
#(
  parameter int MAX_BURST  = MAX_BURST_DEF,
  parameter int EVENT_BITS = EVENT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    command,
  input  logic [CREDIT_W-1:0] credit_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                is_trigger,
  output logic [EV_OUT_W-1:0] event_number,
  output logic [RUN_W-1:0]    run_number,
  output logic [SRC_W-1:0]    trigger_source,
  output logic [STATE_W-1:0]  state_code,
  output logic                accepted,
  output logic                last
);

  ctl_cmd_t    cmd;
  ctl_status_t status;

  assign pready = 1'b1;

  ctd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ctd_datapath #(
    .MAX_BURST  (MAX_BURST),
    .EVENT_BITS (EVENT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .command        (command),
    .credit_count   (credit_count),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .is_trigger     (is_trigger),
    .event_number   (event_number),
    .run_number     (run_number),
    .trigger_source (trigger_source),
    .state_code     (state_code),
    .accepted       (accepted),
    .last           (last)
  );

endmodule
